// ===== sv/imc_pkg.sv =====
// Shared constants, kernel weight table and register codes for the
// image mask convolution core. No dependencies.
`default_nettype none

package imc_pkg;

  localparam int MAX_COLUMNS_DEF = 1024;
  localparam int PIXEL_BITS_DEF  = 8;
  localparam int ROWS_LIMIT      = 1024;
  localparam int FILT_W          = 19;
  localparam int KIND_COUNT      = 11;
  localparam int TAPS            = 25;
  localparam int WIN             = 5;
  localparam int DIV_GAUSS       = 159;
  localparam int DIV_SMALL_GAUSS = 99;

  // kernel codes that change the divisor
  localparam logic [3:0] KIND_GAUSS       = 4'd0;
  localparam logic [3:0] KIND_SMALL_GAUSS = 4'd1;

  // divisor select
  localparam logic [1:0] DIV_SEL_8     = 2'd0;
  localparam logic [1:0] DIV_SEL_159   = 2'd1;
  localparam logic [1:0] DIV_SEL_99    = 2'd2;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_MASK_KIND = 2'd0;
  localparam logic [1:0] REG_COLUMNS   = 2'd1;
  localparam logic [1:0] REG_ROWS      = 2'd2;

  // weights times 4, row-major over the 5x5 window
  localparam logic signed [7:0] KERNEL [KIND_COUNT][TAPS] = '{
    '{8,16,20,16,8, 16,36,48,36,16, 20,48,60,48,20, 16,36,48,36,16, 8,16,20,16,8},
    '{0,0,0,0,0, 0,36,48,36,0, 0,48,60,48,0, 0,36,48,36,0, 0,0,0,0,0},
    '{4,4,4,4,4, 4,4,4,4,4, 4,4,-96,4,4, 4,4,4,4,4, 4,4,4,4,4},
    '{0,0,0,0,0, 0,4,4,4,0, 0,4,-32,4,0, 0,4,4,4,0, 0,0,0,0,0},
    '{0,0,0,0,0, 0,0,0,0,0, 0,-2,0,2,0, 0,0,0,0,0, 0,0,0,0,0},
    '{0,0,0,0,0, 0,0,-2,0,0, 0,0,0,0,0, 0,0,2,0,0, 0,0,0,0,0},
    '{0,0,0,0,0, 0,0,4,0,0, 0,0,-8,0,0, 0,0,4,0,0, 0,0,0,0,0},
    '{0,0,0,0,0, 0,0,0,0,0, 0,4,-8,4,0, 0,0,0,0,0, 0,0,0,0,0},
    '{0,0,0,0,0, 0,1,0,-1,0, 0,0,0,0,0, 0,-1,0,1,0, 0,0,0,0,0},
    '{0,0,0,0,0, 0,-4,0,4,0, 0,-8,0,8,0, 0,-4,0,4,0, 0,0,0,0,0},
    '{0,0,0,0,0, 0,4,8,4,0, 0,0,0,0,0, 0,-4,-8,-4,0, 0,0,0,0,0}
  };

  function automatic logic signed [7:0] coef(input logic [3:0] kind, input logic [4:0] tap);
    logic signed [7:0] w;
    w = '0;
    if (kind < 4'(KIND_COUNT)) begin
      w = KERNEL[kind][tap];
    end
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== sv/imc_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module imc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/imc_kernel.sv =====
// Weighted 5x5 sum with border replacement, scaling and division by the
// kernel's divisor; three register stages. Depends on imc_pkg.
`default_nettype none

module imc_kernel import imc_pkg::*; #(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int PIXEL_BITS  = PIXEL_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            valid_i,
  output logic                                 ready_o,
  input  wire logic [PIXEL_BITS-1:0]           win_i [TAPS],
  input  wire logic                            last_i,
  input  wire logic [9:0]                      orow_i,
  input  wire logic [$clog2(MAX_COLUMNS)-1:0]  ocol_i,
  input  wire logic [3:0]                      kind_i,
  input  wire logic [$clog2(MAX_COLUMNS):0]    cols_i,
  input  wire logic [10:0]                     rows_i,
  output logic                                 valid_o,
  input  wire logic                            ready_i,
  output logic      [FILT_W-1:0]               filt_o,
  output logic                                 last_o
);

  localparam int CW  = $clog2(MAX_COLUMNS);
  localparam int CEW = CW + 1;
  localparam int RSW = PIXEL_BITS + 12;
  localparam int SW  = PIXEL_BITS + 15;
  localparam int MW  = SW + 6;
  localparam int K   = MW + 8;
  localparam int RBW = K - 6;
  localparam longint unsigned R159 = ((64'd1 << K) + 64'(DIV_GAUSS) - 64'd1) / 64'(DIV_GAUSS);
  localparam longint unsigned R99  =
    ((64'd1 << K) + 64'(DIV_SMALL_GAUSS) - 64'd1) / 64'(DIV_SMALL_GAUSS);

  // stage 1: row sums
  logic                  k1_valid_q, k1_last_q;
  logic [1:0]            k1_sel_q;
  logic signed [RSW-1:0] k1_row_q [WIN];
  logic signed [RSW-1:0] row_d [WIN];
  logic [WIN-1:0]        row_ok, col_ok;
  logic [1:0]            sel_d;

  // stage 2: magnitude
  logic                  k2_valid_q, k2_last_q, k2_neg_q;
  logic [1:0]            k2_sel_q;
  logic [MW-1:0]         k2_mag_q;
  logic signed [SW-1:0]  sum_d;
  logic [SW-1:0]         abs_d;

  // stage 3: quotient
  logic                  out_valid_q, out_last_q;
  logic [FILT_W-1:0]     out_filt_q;
  logic [MW+RBW-1:0]     prod;
  logic [MW-1:0]         quot;
  logic [FILT_W-1:0]     filt_d;

  logic k1_ready, k2_ready, out_ready;

  assign out_ready = !out_valid_q || ready_i;
  assign k2_ready  = !k2_valid_q || out_ready;
  assign k1_ready  = !k1_valid_q || k2_ready;
  assign ready_o   = k1_ready;

  always_comb begin
    row_ok[0] = orow_i >= 10'd2;
    row_ok[1] = orow_i >= 10'd1;
    row_ok[2] = 1'b1;
    row_ok[3] = (11'(orow_i) + 11'd1) < rows_i;
    row_ok[4] = (11'(orow_i) + 11'd2) < rows_i;
    col_ok[0] = ocol_i >= CW'(2);
    col_ok[1] = ocol_i >= CW'(1);
    col_ok[2] = 1'b1;
    col_ok[3] = (CEW'(ocol_i) + CEW'(1)) < cols_i;
    col_ok[4] = (CEW'(ocol_i) + CEW'(2)) < cols_i;
  end

  always_comb begin
    logic [PIXEL_BITS-1:0] v;
    for (int r = 0; r < WIN; r++) begin
      row_d[r] = '0;
      for (int c = 0; c < WIN; c++) begin
        // outside the image the centre pixel stands in
        v = (row_ok[r] && col_ok[c]) ? win_i[r*WIN+c] : win_i[TAPS/2];
        row_d[r] = row_d[r] + RSW'($signed({1'b0, v})) * RSW'(coef(kind_i, 5'(r*WIN+c)));
      end
    end
  end

  always_comb begin
    case (kind_i)
      KIND_GAUSS:       sel_d = DIV_SEL_159;
      KIND_SMALL_GAUSS: sel_d = DIV_SEL_99;
      default:          sel_d = DIV_SEL_8;
    endcase
  end

  always_comb begin
    sum_d = '0;
    for (int r = 0; r < WIN; r++) begin
      sum_d = sum_d + SW'(k1_row_q[r]);
    end
    abs_d = sum_d[SW-1] ? SW'(-sum_d) : SW'(sum_d);
  end

  always_comb begin
    prod = '0;
    case (k2_sel_q)
      DIV_SEL_159: prod = (MW+RBW)'(k2_mag_q) * (MW+RBW)'(R159);
      DIV_SEL_99:  prod = (MW+RBW)'(k2_mag_q) * (MW+RBW)'(R99);
      default:     prod = '0;
    endcase
    quot = (k2_sel_q == DIV_SEL_8) ? (k2_mag_q >> 3) : MW'(prod >> K);
    filt_d = k2_neg_q ? FILT_W'(-quot) : FILT_W'(quot);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k1_valid_q  <= 1'b0;
      k2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (k1_ready) begin
        k1_valid_q <= valid_i;
      end
      if (k2_ready) begin
        k2_valid_q <= k1_valid_q;
      end
      if (out_ready) begin
        out_valid_q <= k2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (k1_ready && valid_i) begin
      k1_row_q  <= row_d;
      k1_last_q <= last_i;
      k1_sel_q  <= sel_d;
    end
    if (k2_ready && k1_valid_q) begin
      k2_mag_q  <= {abs_d, 6'b0};
      k2_neg_q  <= sum_d[SW-1];
      k2_sel_q  <= k1_sel_q;
      k2_last_q <= k1_last_q;
    end
    if (out_ready && k2_valid_q) begin
      out_filt_q <= filt_d;
      out_last_q <= k2_last_q;
    end
  end

  assign valid_o = out_valid_q;
  assign filt_o  = out_filt_q;
  assign last_o  = out_last_q;

endmodule

`default_nettype wire

// ===== sv/image_mask_convolution_core.sv =====
// Streaming 5x5 image convolution; one item per cycle, sustained while
// the result port is not stalled. A result passes the accept register
// and line store read, then 3 arithmetic stages, before the result
// port; outputs trail inputs by 2*columns+2 items within a frame.
// Reset (rst_ni low, asynchronous) clears counters, window and valid
// flags; line store contents are not cleared and need no clearing pass.
`default_nettype none

module image_mask_convolution_core import imc_pkg::*; #(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int PIXEL_BITS  = PIXEL_BITS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  input  wire logic [((PIXEL_BITS+7)/8)*8-1:0]       s_axis_tdata,  // pixel
  input  wire logic                                  s_axis_tuser,  // func
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  output logic      [23:0]                           m_axis_tdata,  // filtered
  output logic                                       m_axis_tlast,  // frame_end
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [3:0]                            paddr,
  input  wire logic [31:0]                           pwdata,
  output logic      [31:0]                           prdata,
  output logic                                       pready
);

  localparam int CW  = $clog2(MAX_COLUMNS);
  localparam int CEW = CW + 1;
  localparam int PW  = CW + 11;
  localparam int LW  = 4 * PIXEL_BITS;

  logic [3:0]  mask_kind_q;
  logic [10:0] cols_q, rows_q;
  logic [CEW-1:0] cols_e;
  logic [10:0]    rows_e;

  logic [CW-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [10:0]   in_row_q, in_row_d;
  logic [9:0]    out_row_q, out_row_d;
  logic [PW-1:0] pos_q, pos_d;

  logic                  a_valid_q, a_emit_q, a_last_q;
  logic [PIXEL_BITS-1:0] a_pix_q;
  logic [1:0]            a_lane_q;
  logic [CW-1:0]         a_col_q, a_ocol_q;
  logic [9:0]            a_orow_q;
  logic                  fwd_q;
  logic [LW-1:0]         fwd_word_q;

  logic                  acc, a_adv, k_ready, cfg_wr, emit, last;
  logic [PIXEL_BITS-1:0] pix;
  logic [LW-1:0]         ram_rdata, rd_word, wr_word;
  logic [PIXEL_BITS-1:0] colvec [WIN];
  logic [PIXEL_BITS-1:0] win_q [TAPS];
  logic [PIXEL_BITS-1:0] win_d [TAPS];
  logic [FILT_W-1:0]     filt;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[3:2])
      REG_MASK_KIND: prdata = {28'b0, mask_kind_q};
      REG_COLUMNS:   prdata = {21'b0, cols_q};
      REG_ROWS:      prdata = {21'b0, rows_q};
      default:       prdata = '0;
    endcase
  end

  always_comb begin
    if (cols_q == 11'd0) begin
      cols_e = CEW'(1);
    end else if (32'(cols_q) > MAX_COLUMNS) begin
      cols_e = CEW'(MAX_COLUMNS);
    end else begin
      cols_e = CEW'(cols_q);
    end
    if (rows_q == 11'd0) begin
      rows_e = 11'd1;
    end else if (32'(rows_q) > ROWS_LIMIT) begin
      rows_e = 11'(ROWS_LIMIT);
    end else begin
      rows_e = rows_q;
    end
  end

  assign a_adv         = a_valid_q && k_ready;
  assign s_axis_tready = !a_valid_q || k_ready;
  assign acc           = s_axis_tvalid && s_axis_tready;

  // frame position bookkeeping for the accepted request
  always_comb begin
    pix  = ((in_row_q < rows_e) && !s_axis_tuser) ? s_axis_tdata[PIXEL_BITS-1:0] : '0;
    emit = pos_q >= (PW'(cols_e) + PW'(cols_e) + PW'(2));
    last = emit && ((11'(out_row_q) + 11'd1) >= rows_e) &&
           ((CEW'(out_col_q) + CEW'(1)) >= cols_e);
    in_col_d  = in_col_q + CW'(1);
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    pos_d     = pos_q + PW'(1);
    if ((CEW'(in_col_q) + CEW'(1)) >= cols_e) begin
      in_col_d = '0;
      in_row_d = in_row_q + 11'd1;
    end
    if (emit) begin
      out_col_d = out_col_q + CW'(1);
      if ((CEW'(out_col_q) + CEW'(1)) >= cols_e) begin
        out_col_d = '0;
        out_row_d = out_row_q + 10'd1;
      end
    end
    if (last) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
      pos_d     = '0;
    end
  end

  // lane r of a line store word holds the row whose index mod 4 is r
  always_comb begin
    rd_word = fwd_q ? fwd_word_q : ram_rdata;
    for (int k = 0; k < 4; k++) begin
      colvec[k] = rd_word[PIXEL_BITS*(2'(a_lane_q + 2'(k))) +: PIXEL_BITS];
    end
    colvec[4] = a_pix_q;
    wr_word = rd_word;
    wr_word[PIXEL_BITS*a_lane_q +: PIXEL_BITS] = a_pix_q;
  end

  always_comb begin
    win_d = win_q;
    if (a_adv) begin
      for (int k = 0; k < WIN; k++) begin
        for (int j = 0; j < WIN-1; j++) begin
          win_d[k*WIN+j] = win_q[k*WIN+j+1];
        end
        win_d[k*WIN+WIN-1] = colvec[k];
      end
    end
  end

  imc_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_COLUMNS)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (a_adv),
    .waddr_i (a_col_q),
    .wdata_i (wr_word),
    .re_i    (acc),
    .raddr_i (in_col_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_kind_q <= '0;
      cols_q      <= 11'd1024;
      rows_q      <= 11'd1024;
      in_col_q    <= '0;
      in_row_q    <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      pos_q       <= '0;
      a_valid_q   <= 1'b0;
      fwd_q       <= 1'b0;
      for (int i = 0; i < TAPS; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      win_q <= win_d;
      if (a_adv || acc) begin
        a_valid_q <= acc;
      end
      if (acc) begin
        in_col_q  <= in_col_d;
        in_row_q  <= in_row_d;
        out_col_q <= out_col_d;
        out_row_q <= out_row_d;
        pos_q     <= pos_d;
        // same column written while being read: take the new word
        fwd_q     <= a_adv && (a_col_q == in_col_q);
      end
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_MASK_KIND: mask_kind_q <= pwdata[3:0];
          REG_COLUMNS:   cols_q      <= pwdata[10:0];
          REG_ROWS:      rows_q      <= pwdata[10:0];
          default:       ;
        endcase
        if (paddr[3:2] == REG_COLUMNS || paddr[3:2] == REG_ROWS) begin
          in_col_q  <= '0;
          in_row_q  <= '0;
          out_col_q <= '0;
          out_row_q <= '0;
          pos_q     <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      a_pix_q    <= pix;
      a_lane_q   <= in_row_q[1:0];
      a_col_q    <= in_col_q;
      a_emit_q   <= emit;
      a_last_q   <= last;
      a_orow_q   <= out_row_q;
      a_ocol_q   <= out_col_q;
      fwd_word_q <= wr_word;
    end
  end

  imc_kernel #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .PIXEL_BITS  (PIXEL_BITS)
  ) u_kernel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (a_adv && a_emit_q),
    .ready_o (k_ready),
    .win_i   (win_d),
    .last_i  (a_last_q),
    .orow_i  (a_orow_q),
    .ocol_i  (a_ocol_q),
    .kind_i  (mask_kind_q),
    .cols_i  (cols_e),
    .rows_i  (rows_e),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .filt_o  (filt),
    .last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {5'b0, filt};

endmodule

`default_nettype wire

// ===== sv/imc_checker.sv =====
// Port-level checks for image_mask_convolution_core, bound to the top.
// Depends on imc_pkg and the top level's port list.
`default_nettype none

module imc_checker import imc_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [3:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[23:19] == 5'b0)
    else $error("tdata fill bits not zero");

  a_kind_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && paddr[3:2] == REG_MASK_KIND |=>
      paddr[3:2] != REG_MASK_KIND || prdata[3:0] == $past(pwdata[3:0]))
    else $error("mask_kind readback mismatch");

endmodule

bind image_mask_convolution_core imc_checker u_imc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata)
);

`default_nettype wire
